[hdl/hda_pkg.sv]
// Shared types, fixed-point constants and the arctangent table for the
// haversine distance accumulator. No dependencies.
`default_nettype none
package hda_pkg;

  localparam int DW = 40;   // datapath word, signed Q30 angles and trig values
  localparam int PW = 80;   // full product width

  localparam logic signed [DW-1:0] Q30_ONE     = 40'sd1073741824;
  localparam logic signed [DW-1:0] Q30_PI      = 40'sd3373259426;
  localparam logic signed [DW-1:0] Q30_HALF_PI = 40'sd1686629713;
  localparam logic signed [DW-1:0] Q30_TWO_PI  = 40'sd6746518852;
  localparam logic signed [DW-1:0] DEG2RAD_Q32 = 40'sd74961321;
  localparam logic signed [DW-1:0] CORDIC_GAIN = 40'sd652032874;

  localparam logic [47:0] TOTAL_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] SEGMENT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_BUSY,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    STEP_LAT1, STEP_LAT2, STEP_DLAT, STEP_DLON,
    STEP_ROT1, STEP_ROT2, STEP_ROTA, STEP_ROTB,
    STEP_SASQ, STEP_C1C2, STEP_SBSQ, STEP_PROD,
    STEP_SQA,  STEP_SQB,  STEP_VEC,  STEP_DIST
  } step_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RED,
    CS_ITER
  } cstate_t;

  typedef struct packed {
    logic start;
    logic vector;   // 1: atan2 (vectoring), 0: sin/cos (rotation)
  } cordic_cmd_t;

  function automatic logic signed [DW-1:0] atan_entry(input logic [5:0] i);
    logic signed [DW-1:0] r;
    r = '0;
    case (i)
      6'd0: r = 40'sd843314857;
      6'd1: r = 40'sd497837829;
      6'd2: r = 40'sd263043837;
      6'd3: r = 40'sd133525159;
      6'd4: r = 40'sd67021687;
      6'd5: r = 40'sd33543516;
      6'd6: r = 40'sd16775851;
      6'd7: r = 40'sd8388437;
      6'd8: r = 40'sd4194283;
      6'd9: r = 40'sd2097149;
      default: begin
        if (i <= 6'd30) r = 40'sd1 <<< (6'd30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/hda_mul.sv]
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on hda_pkg.
`default_nettype none
module hda_mul
  import hda_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] a,
  input  wire logic signed [DW-1:0] b,
  output logic                      done,
  output logic signed [PW-1:0]      p
);

  localparam int CW = $clog2(DW);

  logic signed [PW-1:0] mcand;
  logic        [DW-1:0] mplier;
  logic        [CW-1:0] cnt;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CW'(DW - 1));
      if (start) begin
        busy   <= 1'b1;
        p      <= '0;
        mcand  <= PW'(a);
        mplier <= b;
        cnt    <= '0;
      end else if (busy) begin
        // top bit of b carries negative weight
        if (mplier[0]) begin
          if (cnt == CW'(DW - 1)) p <= p - mcand;
          else p <= p + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) busy <= 1'b0;
      end
    end
  end

  // done only ever follows a running multiply
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("multiplier done without a pass");

endmodule
`default_nettype wire

[hdl/hda_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle: sin/cos with range
// reduction, or atan2 for non-negative inputs. Depends on hda_pkg.
`default_nettype none
module hda_cordic
  import hda_pkg::*;
#(
  parameter int CORDIC_STEPS = 28
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cordic_cmd_t          cmd,
  input  wire logic signed [DW-1:0] ang,
  input  wire logic signed [DW-1:0] x_in,
  input  wire logic signed [DW-1:0] y_in,
  output logic                      done,
  output logic signed [DW-1:0]      cos_out,
  output logic signed [DW-1:0]      sin_out,
  output logic signed [DW-1:0]      z_out
);

  localparam int IW = $clog2(CORDIC_STEPS);

  cstate_t              state, state_next;
  logic signed [DW-1:0] x, y, z;
  logic                 flip, vector;
  logic        [IW-1:0] i;

  logic signed [DW-1:0] sx, sy, at;
  logic                 plus, last;

  assign sx   = x >>> i;
  assign sy   = y >>> i;
  assign at   = atan_entry(6'(i));
  assign plus = vector ? (y <= 0) : (z >= 0);
  assign last = (i == IW'(CORDIC_STEPS - 1));

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;
  assign z_out   = z;

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: if (cmd.start) state_next = cmd.vector ? CS_ITER : CS_RED;
      CS_RED:  if (z <= Q30_PI && z >= -Q30_PI) state_next = CS_ITER;
      CS_ITER: if (last) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == CS_ITER) && last;
      case (state)
        CS_IDLE: begin
          if (cmd.start) begin
            vector <= cmd.vector;
            flip   <= 1'b0;
            i      <= '0;
            if (cmd.vector) begin
              x <= x_in;
              y <= y_in;
              z <= '0;
            end else begin
              x <= CORDIC_GAIN;
              y <= '0;
              z <= ang;
            end
          end
        end
        CS_RED: begin
          // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
          if (z > Q30_PI) z <= z - Q30_TWO_PI;
          else if (z < -Q30_PI) z <= z + Q30_TWO_PI;
          else if (z > Q30_HALF_PI) begin
            z    <= z - Q30_PI;
            flip <= 1'b1;
          end else if (z < -Q30_HALF_PI) begin
            z    <= z + Q30_PI;
            flip <= 1'b1;
          end
        end
        CS_ITER: begin
          if (plus) begin
            x <= x - sy;
            y <= y + sx;
            z <= z - at;
          end else begin
            x <= x + sy;
            y <= y - sx;
            z <= z + at;
          end
          i <= i + IW'(1);
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> state == CS_IDLE)
    else $error("cordic done while still rotating");
  assert property (@(posedge clk) disable iff (rst)
                   state == CS_ITER && !vector |-> z <= Q30_PI && z >= -Q30_PI)
    else $error("rotation angle left the reduced range");

endmodule
`default_nettype wire

[hdl/haversine_distance_accumulator.sv]
// Haversine great-circle distance with a saturating running total.
// Each word runs through 9 serial multiplies, 4 sin/cos passes, one atan2
// pass and two square roots, one after another on the shared units.
// One word in flight; the next is taken while a result waits at the output.
// Synchronous reset clears the total, the sequencer and the output valid.
`default_nettype none
module haversine_distance_accumulator
  import hda_pkg::*;
#(
  parameter int EARTH_RADIUS_KM = 6371,
  parameter int CORDIC_STEPS    = 28
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [30:0] start_latitude,
  input  wire logic signed [31:0] start_longitude,
  input  wire logic signed [30:0] end_latitude,
  input  wire logic signed [31:0] end_longitude,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [30:0]             segment_km,
  output logic [47:0]             running_total_km,
  output logic                    total_saturated
);

  localparam logic signed [PW-1:0] HALF25 = PW'(1) <<< 24;
  localparam logic signed [PW-1:0] HALF26 = PW'(1) <<< 25;
  localparam logic signed [PW-1:0] HALF14 = PW'(1) <<< 13;
  localparam logic signed [DW-1:0] RADIUS = DW'(EARTH_RADIUS_KM);

  state_t state, state_next;
  step_t  step;

  logic signed [30:0] lat1, lat2;
  logic signed [31:0] lon1, lon2;
  logic signed [DW-1:0] va, vb, vc, vd;
  logic [30:0] seg;
  logic [47:0] total;

  // shared units
  logic                 mul_start, mul_done, cor_done, sq_start, sq_done, sq_busy;
  logic signed [DW-1:0] mul_a, mul_b, cor_ang, cor_cos, cor_sin, cor_z;
  logic signed [PW-1:0] mul_p;
  cordic_cmd_t          cmd;
  logic [61:0]          sq_v, sq_res, sq_bit, sq_sum;

  logic signed [DW-1:0] a_sum, c2z;
  logic [30:0]          a_clamp;
  logic signed [PW-1:0] p25, p26, p30, p14;
  logic [30:0]          seg_new;
  logic [48:0]          tot_sum;
  logic [47:0]          tot_new;
  logic                 unit_done, finish;

  hda_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  hda_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .cmd(cmd), .ang(cor_ang), .x_in(vd), .y_in(va),
    .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin), .z_out(cor_z)
  );

  assign unit_done = mul_done | cor_done | sq_done;
  assign in_ready  = (state == ST_IDLE);
  assign finish    = (state == ST_FINISH) && (!out_valid || out_ready);

  // haversine term, clamped to [0, 1]
  assign a_sum   = vc + vb;
  assign a_clamp = (a_sum < 0) ? '0 : (a_sum > Q30_ONE) ? Q30_ONE[30:0] : a_sum[30:0];

  assign c2z = cor_z <<< 1;
  assign p25 = (mul_p + HALF25) >>> 25;
  assign p26 = (mul_p + HALF26) >>> 26;
  assign p30 = mul_p >>> 30;
  assign p14 = (mul_p + HALF14) >>> 14;
  assign seg_new = (p14 > PW'(SEGMENT_MAX)) ? SEGMENT_MAX : p14[30:0];

  assign tot_sum = {1'b0, total} + 49'(seg);
  assign tot_new = tot_sum[48] ? TOTAL_MAX : tot_sum[47:0];

  assign sq_sum = sq_res + sq_bit;

  always_comb begin
    mul_a   = va;
    mul_b   = DEG2RAD_Q32;
    cor_ang = va;
    case (step)
      STEP_LAT1: mul_a = DW'(lat1);
      STEP_LAT2: mul_a = DW'(lat2);
      STEP_DLAT: mul_a = DW'(lat2) - DW'(lat1);
      STEP_DLON: mul_a = DW'(lon2) - DW'(lon1);
      STEP_ROT2: cor_ang = vb;
      STEP_ROTA: cor_ang = vc;
      STEP_ROTB: cor_ang = vd;
      STEP_SASQ: begin mul_a = vc; mul_b = vc; end
      STEP_C1C2: begin mul_a = va; mul_b = vb; end
      STEP_SBSQ: begin mul_a = vd; mul_b = vd; end
      STEP_PROD: begin mul_a = va; mul_b = vd; end
      STEP_DIST: begin mul_a = va; mul_b = RADIUS; end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sq_start   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_ISSUE;
      ST_ISSUE: begin
        state_next = ST_BUSY;
        case (step)
          STEP_ROT1, STEP_ROT2, STEP_ROTA, STEP_ROTB: cmd.start = 1'b1;
          STEP_VEC: begin
            cmd.start  = 1'b1;
            cmd.vector = 1'b1;
          end
          STEP_SQA, STEP_SQB: sq_start = 1'b1;
          default: mul_start = 1'b1;
        endcase
      end
      ST_BUSY:   if (unit_done) state_next = (step == STEP_DIST) ? ST_FINISH : ST_ISSUE;
      ST_FINISH: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // bitwise integer square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= sq_busy && !sq_start && (sq_bit == 62'd1);
      if (sq_start) begin
        sq_busy <= 1'b1;
        sq_res  <= '0;
        sq_bit  <= 62'd1 << 60;
        if (step == STEP_SQA) sq_v <= 62'({a_clamp, 30'd0});
        else sq_v <= 62'({Q30_ONE[30:0] - a_clamp, 30'd0});
      end else if (sq_busy) begin
        if (sq_v >= sq_sum) begin
          sq_v   <= sq_v - sq_sum;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit == 62'd1) sq_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_LAT1;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        lat1 <= start_latitude;
        lon1 <= start_longitude;
        lat2 <= end_latitude;
        lon2 <= end_longitude;
        step <= STEP_LAT1;
      end
      if (state == ST_BUSY && unit_done) begin
        case (step)
          STEP_LAT1: va <= p25[DW-1:0];
          STEP_LAT2: vb <= p25[DW-1:0];
          STEP_DLAT: vc <= p26[DW-1:0];
          STEP_DLON: vd <= p26[DW-1:0];
          STEP_ROT1: va <= cor_cos;
          STEP_ROT2: vb <= cor_cos;
          STEP_ROTA: vc <= cor_sin;
          STEP_ROTB: vd <= cor_sin;
          STEP_SASQ: vc <= p30[DW-1:0];
          STEP_C1C2: va <= p30[DW-1:0];
          STEP_SBSQ: vd <= p30[DW-1:0];
          STEP_PROD: vb <= p30[DW-1:0];
          STEP_SQA:  va <= $signed(sq_res[DW-1:0]);
          STEP_SQB:  vd <= $signed(sq_res[DW-1:0]);
          STEP_VEC:  va <= (c2z < 0) ? '0 : c2z;
          STEP_DIST: seg <= seg_new;
          default: ;
        endcase
        step <= step_t'(step + 4'd1);
      end
      if (out_valid && out_ready && !finish) out_valid <= 1'b0;
      if (finish) begin
        total            <= tot_new;
        segment_km       <= seg;
        running_total_km <= tot_new;
        total_saturated  <= (tot_new == TOTAL_MAX);
        out_valid        <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) total >= $past(total))
    else $error("running total went down");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> total_saturated == (running_total_km == TOTAL_MAX))
    else $error("saturation flag disagrees with total");
  assert property (@(posedge clk) disable iff (rst) unit_done |-> state == ST_BUSY)
    else $error("unit finished outside of a busy step");
  assert property (@(posedge clk) disable iff (rst)
                   $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result word loaded outside of finish");

endmodule
`default_nettype wire

[tb/hda_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the haversine distance accumulator: predicts each segment
// distance and running total from accepted input words and compares them.
// Depends on hda_pkg for the total and segment limits.
module hda_checker
  import hda_pkg::*;
#(
  parameter int EARTH_RADIUS_KM = 6371,
  parameter int CORDIC_STEPS    = 28
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [30:0] start_latitude,
  input  wire logic signed [31:0] start_longitude,
  input  wire logic signed [30:0] end_latitude,
  input  wire logic signed [31:0] end_longitude,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [30:0]        segment_km,
  input  wire logic [47:0]        running_total_km,
  input  wire logic               total_saturated,
  output int                      errors,
  output int                      pending
);

  localparam longint ONE      = 64'sd1073741824;
  localparam longint PI       = 64'sd3373259426;
  localparam longint HALF_PI  = 64'sd1686629713;
  localparam longint TWO_PI   = 64'sd6746518852;
  localparam longint RAD_PER_DEG = 64'sd74961321;
  localparam longint GAIN_INV = 64'sd652032874;

  typedef struct {
    logic [30:0] seg;
    logic [47:0] total;
    logic        sat;
  } distance_t;

  distance_t   expected_q[$];
  logic [47:0] total_km;

  function automatic longint arc_step(int i);
    case (i)
      0: return 64'sd843314857;
      1: return 64'sd497837829;
      2: return 64'sd263043837;
      3: return 64'sd133525159;
      4: return 64'sd67021687;
      5: return 64'sd33543516;
      6: return 64'sd16775851;
      7: return 64'sd8388437;
      8: return 64'sd4194283;
      9: return 64'sd2097149;
      default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
    endcase
  endfunction

  function automatic longint to_radians(longint deg, int sh);
    return (deg * RAD_PER_DEG + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_INV; y = 0; z = ang; flip = 0;
    while (z > PI) z -= TWO_PI;
    while (z < -PI) z += TWO_PI;
    if (z > HALF_PI) begin
      z -= PI; flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, nx;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned segment_of(longint lat1, longint lon1,
                                                 longint lat2, longint lon2);
    longint s1, c1, s2, c2, sa, ca, sb, cb, a, c;
    longint unsigned ra, rb, seg;
    sin_cos(to_radians(lat1, 25), s1, c1);
    sin_cos(to_radians(lat2, 25), s2, c2);
    sin_cos(to_radians(lat2 - lat1, 26), sa, ca);
    sin_cos(to_radians(lon2 - lon1, 26), sb, cb);
    a = qmul(sa, sa) + qmul(qmul(c1, c2), qmul(sb, sb));
    if (a < 0) a = 0;
    if (a > ONE) a = ONE;
    ra = root_of(longint'(a) << 30);
    rb = root_of(longint'(ONE - a) << 30);
    c = 2 * angle_of(longint'(ra), longint'(rb));
    if (c < 0) c = 0;
    seg = (longint'(EARTH_RADIUS_KM) * c + 64'd8192) >> 14;
    if (seg > SEGMENT_MAX) seg = SEGMENT_MAX;
    return seg;
  endfunction

  always @(posedge clk) begin
    distance_t d;
    longint unsigned seg;
    if (rst) begin
      expected_q.delete();
      total_km <= '0;
      errors   <= 0;
      pending  <= 0;
    end else begin
      d = '{default: '0};
      if (in_valid && in_ready) begin
        seg = segment_of(start_latitude, start_longitude, end_latitude, end_longitude);
        if ({16'd0, total_km} > {16'd0, TOTAL_MAX} - seg) d.total = TOTAL_MAX;
        else d.total = total_km + seg[47:0];
        d.seg = seg[30:0];
        d.sat = (d.total == TOTAL_MAX);
        total_km <= d.total;
        expected_q.push_back(d);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: segment_km %0d", segment_km);
          errors <= errors + 1;
        end else begin
          d = expected_q.pop_front();
          if (segment_km !== d.seg || running_total_km !== d.total ||
              total_saturated !== d.sat) begin
            errors <= errors + 1;
            if (segment_km !== d.seg)
              $error("segment_km expected %0d actual %0d", d.seg, segment_km);
            if (running_total_km !== d.total)
              $error("running_total_km expected %0d actual %0d", d.total,
                     running_total_km);
            if (total_saturated !== d.sat)
              $error("total_saturated expected %0d actual %0d", d.sat,
                     total_saturated);
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

[tb/tb_haversine_distance_accumulator.sv]
`timescale 1ns / 1ps
// Top of the distance accumulator testbench: clock, reset, stimulus and verdict.
// Depends on hda_pkg, the block itself and hda_checker.
module tb_haversine_distance_accumulator;

  localparam longint DEG   = 64'sd8388608;
  localparam longint LAT90 = 90 * DEG;
  localparam longint LON180 = 180 * DEG;
  localparam int     STALL_LIMIT = 6000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic signed [30:0] start_latitude = '0, end_latitude = '0;
  logic signed [31:0] start_longitude = '0, end_longitude = '0;
  logic in_ready, out_valid, total_saturated;
  logic [30:0] segment_km;
  logic [47:0] running_total_km;
  int errors, pending, idle_cycles;
  bit quiet;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  haversine_distance_accumulator DUT (.*);
  hda_checker checker_i (.*);

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // receiver: stalls in bursts until the quiet tail
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  task automatic send(longint lat1, longint lon1, longint lat2, longint lon2);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid        <= 1;
    start_latitude  <= lat1[30:0];
    start_longitude <= lon1[31:0];
    end_latitude    <= lat2[30:0];
    end_longitude   <= lon2[31:0];
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic longint rnd_lat();
    return longint'($urandom_range(0, 2 * LAT90)) - LAT90;
  endfunction

  function automatic longint rnd_lon();
    return longint'($urandom_range(0, 2 * LON180)) - LON180;
  endfunction

  initial begin
    longint la, lo;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed words
    send(0, 0, 0, 0);
    send(45 * DEG, 10 * DEG, 45 * DEG, 10 * DEG);
    send(0, 0, 0, LON180);                  // antipodal on the equator
    send(LAT90, 0, -LAT90, 0);              // pole to pole
    send(LAT90, 0, LAT90, LON180);          // both at a pole
    send(-LAT90, -LON180, LAT90, LON180);
    send(0, -LON180, 0, LON180);            // same meridian both ways round
    send(1, 0, 0, 1);                       // one-lsb distance
    send(0, 0, 0, 1);
    send(30 * DEG, 20 * DEG, 30 * DEG + 5, 20 * DEG - 7);
    send(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
    send((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
    send(100 * DEG, 0, 10 * DEG, 90 * DEG); // latitude past the pole
    send(-120 * DEG, 270 * DEG, 60 * DEG, -200 * DEG);
    send(51 * DEG, 0, 40 * DEG, -74 * DEG);
    send(-33 * DEG, 151 * DEG, 35 * DEG, -139 * DEG);
    // random words: mostly valid points, some short hops, some raw bit patterns
    for (int i = 0; i < 1150; i++) begin
      if (i >= 1050) quiet = 1;
      case ($urandom_range(0, 9))
        0, 1: send($urandom, $urandom, $urandom, $urandom);
        2, 3: begin
          la = rnd_lat(); lo = rnd_lon();
          send(la, lo, la + $urandom_range(0, 200000) - 100000,
               lo + $urandom_range(0, 200000) - 100000);
        end
        default: send(rnd_lat(), rnd_lon(), rnd_lat(), rnd_lon());
      endcase
    end
    in_valid <= 0;
    // let the checker count the last word before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (errors == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
